[hw/rtl/enhanced_clock_page_replacement_top_macros.svh]
// assertion macros shared by the clock page replacement rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ENHANCED_CLOCK_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define ENHANCED_CLOCK_PAGE_REPLACEMENT_TOP_MACROS_SVH

// plain property, held off while reset is high
`define ECPR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ECPR_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ECPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/ecpr_pkg.sv]
// shared types and constants of the clock page replacement block
// no dependencies; used by the interfaces and every module
`default_nettype none

package ecpr_pkg;

   localparam int PAGE_NUMBER_W = 20;
   localparam int SLOT_FIELD_W  = 3;
   localparam int STATUS_W      = 2;
   localparam int CMD_W         = 2;
   localparam int SCAN_PASSES   = 3;

   // request commands
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd1;
   localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic [PAGE_NUMBER_W-1:0] page_number;
      logic [SLOT_FIELD_W-1:0]  slot_index;
      logic                     write_access;
   } request_type;

   typedef struct packed {
      logic [PAGE_NUMBER_W-1:0] victim_page;
      logic [SLOT_FIELD_W-1:0]  slot_out;
      logic [STATUS_W-1:0]      status;
   } result_type;

   // updates to the per-slot flag bits
   typedef enum logic [2:0] {
      FLAG_NONE,
      FLAG_MARK,
      FLAG_MARK_WRITE,
      FLAG_CLR_ACC,
      FLAG_CLR_DIRTY,
      FLAG_FILL,
      FLAG_FREE
   } flag_op_type;

   typedef struct packed {
      logic        link_we;
      logic        page_we;
      flag_op_type flag_op;
   } store_op_type;

   typedef struct packed {
      logic used;
      logic accessed;
      logic dirty;
   } flags_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_FIND,
      ST_INS_LINK,
      ST_INS_HAND,
      ST_VIC_FIRST,
      ST_VIC_EVAL,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/ecpr_ifs.sv]
// valid/ready channel interfaces for requests and responses
// depends on ecpr_pkg for the payload structs
`default_nettype none

interface ecpr_req_if;
   logic                     valid;
   logic                     ready;
   ecpr_pkg::request_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ecpr_rsp_if;
   logic                     valid;
   logic                     ready;
   ecpr_pkg::result_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/ecpr_frame_store.sv]
// frame storage: page memory, scan link memory and per-slot flag bits
// depends on ecpr_pkg
`default_nettype none

module ecpr_frame_store #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 20,
   parameter int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
   input  wire                         clock,
   input  wire                         reset,
   input  ecpr_pkg::store_op_type      op,
   input  wire  [SLOT_W-1:0]           link_waddr,
   input  wire  [SLOT_W-1:0]           link_wdata,
   input  wire  [SLOT_W-1:0]           link_raddr,
   output logic [SLOT_W-1:0]           link_rdata,
   input  wire  [SLOT_W-1:0]           page_waddr,
   input  wire  [PAGE_BITS-1:0]        page_wdata,
   input  wire  [SLOT_W-1:0]           page_raddr,
   output logic [PAGE_BITS-1:0]        page_rdata,
   input  wire  [SLOT_W-1:0]           flag_addr,
   output ecpr_pkg::flags_type         flags
);

   logic [PAGE_BITS-1:0] page_mem [FRAMES];
   logic [SLOT_W-1:0]    link_mem [FRAMES];
   logic [PAGE_BITS-1:0] page_rdata_ff;
   logic [SLOT_W-1:0]    link_rdata_ff;

   logic [FRAMES-1:0] used_ff, used_in;
   logic [FRAMES-1:0] acc_ff, acc_in;
   logic [FRAMES-1:0] dirty_ff, dirty_in;

   always_ff @(posedge clock) begin
      if (op.page_we) begin
         page_mem[page_waddr] <= page_wdata;
      end
      page_rdata_ff <= page_mem[page_raddr];
   end

   always_ff @(posedge clock) begin
      if (op.link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rdata_ff <= link_mem[link_raddr];
   end

   assign page_rdata = page_rdata_ff;
   assign link_rdata = link_rdata_ff;

   always_comb begin
      used_in  = used_ff;
      acc_in   = acc_ff;
      dirty_in = dirty_ff;
      unique case (op.flag_op)
         ecpr_pkg::FLAG_NONE: begin
         end
         ecpr_pkg::FLAG_MARK: begin
            acc_in[flag_addr] = 1'b1;
         end
         ecpr_pkg::FLAG_MARK_WRITE: begin
            acc_in[flag_addr]   = 1'b1;
            dirty_in[flag_addr] = 1'b1;
         end
         ecpr_pkg::FLAG_CLR_ACC: begin
            acc_in[flag_addr] = 1'b0;
         end
         ecpr_pkg::FLAG_CLR_DIRTY: begin
            dirty_in[flag_addr] = 1'b0;
         end
         ecpr_pkg::FLAG_FILL: begin
            used_in[flag_addr]  = 1'b1;
            acc_in[flag_addr]   = 1'b0;
            dirty_in[flag_addr] = 1'b0;
         end
         ecpr_pkg::FLAG_FREE: begin
            used_in[flag_addr]  = 1'b0;
            acc_in[flag_addr]   = 1'b0;
            dirty_in[flag_addr] = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         acc_ff   <= '0;
         dirty_ff <= '0;
      end else begin
         used_ff  <= used_in;
         acc_ff   <= acc_in;
         dirty_ff <= dirty_in;
      end
   end

   assign flags.used     = used_ff[flag_addr];
   assign flags.accessed = acc_ff[flag_addr];
   assign flags.dirty    = dirty_ff[flag_addr];

endmodule

`default_nettype wire

[hw/rtl/ecpr_sequencer.sv]
// command sequencer: slot search, ring insert and the three-pass victim scan
// depends on ecpr_pkg and the assertion macro header
`default_nettype none
`include "enhanced_clock_page_replacement_top_macros.svh"

module ecpr_sequencer #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 20,
   parameter int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  ecpr_pkg::request_type       req,
   input  wire                         out_free,
   output logic                        done,
   output ecpr_pkg::result_type        result,
   output ecpr_pkg::store_op_type      op,
   output logic [SLOT_W-1:0]           link_waddr,
   output logic [SLOT_W-1:0]           link_wdata,
   output logic [SLOT_W-1:0]           link_raddr,
   input  wire  [SLOT_W-1:0]           link_rdata,
   output logic [SLOT_W-1:0]           page_waddr,
   output logic [PAGE_BITS-1:0]        page_wdata,
   output logic [SLOT_W-1:0]           page_raddr,
   input  wire  [PAGE_BITS-1:0]        page_rdata,
   output logic [SLOT_W-1:0]           flag_addr,
   input  ecpr_pkg::flags_type         flags
);

   localparam int CW = $clog2(FRAMES + 1);
   localparam int IW = ((SLOT_W > ecpr_pkg::SLOT_FIELD_W) ? SLOT_W : ecpr_pkg::SLOT_FIELD_W) + 1;

   ecpr_pkg::state_type  state_ff, state_in;
   logic [SLOT_W-1:0]    hand_ff, hand_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic [SLOT_W-1:0]    cur_ff, cur_in;
   logic [SLOT_W-1:0]    prev_ff, prev_in;
   logic [1:0]           pass_ff, pass_in;
   logic [CW-1:0]        k_ff, k_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   ecpr_pkg::result_type res_ff, res_in;

   logic [IW-1:0] slot_wide;
   logic          victim;
   logic          last_k;

   assign slot_wide = IW'(req.slot_index);
   assign victim    = !flags.accessed && !flags.dirty;
   assign last_k    = (k_ff == count_ff - CW'(1));

   always_comb begin
      state_in   = state_ff;
      hand_in    = hand_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      pass_in    = pass_ff;
      k_in       = k_ff;
      page_in    = page_ff;
      res_in     = res_ff;
      op.link_we = 1'b0;
      op.page_we = 1'b0;
      op.flag_op = ecpr_pkg::FLAG_NONE;
      link_waddr = prev_ff;
      link_wdata = link_rdata;
      link_raddr = hand_ff;
      page_waddr = idx_ff;
      page_wdata = page_ff;
      page_raddr = cur_ff;
      flag_addr  = cur_ff;
      req_ready  = 1'b0;
      done       = 1'b0;
      unique case (state_ff)
         ecpr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            flag_addr = SLOT_W'(slot_wide);
            if (req_valid) begin
               res_in  = '0;
               page_in = PAGE_BITS'(req.page_number);
               unique case (req.cmd)
                  ecpr_pkg::CMD_INSERT: begin
                     if (count_ff == CW'(FRAMES)) begin
                        res_in.status = ecpr_pkg::STATUS_FULL;
                        state_in      = ecpr_pkg::ST_FINISH;
                     end else begin
                        idx_in   = '0;
                        state_in = ecpr_pkg::ST_INS_FIND;
                     end
                  end
                  ecpr_pkg::CMD_ACCESS: begin
                     if ((slot_wide < IW'(FRAMES)) && flags.used) begin
                        op.flag_op = req.write_access ? ecpr_pkg::FLAG_MARK_WRITE
                                                      : ecpr_pkg::FLAG_MARK;
                     end
                     state_in = ecpr_pkg::ST_FINISH;
                  end
                  ecpr_pkg::CMD_VICTIM: begin
                     if (count_ff == '0) begin
                        res_in.status = ecpr_pkg::STATUS_EMPTY;
                        state_in      = ecpr_pkg::ST_FINISH;
                     end else begin
                        prev_in  = hand_ff;
                        pass_in  = '0;
                        k_in     = '0;
                        state_in = ecpr_pkg::ST_VIC_FIRST;
                     end
                  end
                  default: begin
                     state_in = ecpr_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         ecpr_pkg::ST_INS_FIND: begin
            flag_addr = idx_ff;
            if (flags.used) begin
               idx_in = idx_ff + SLOT_W'(1);
            end else begin
               state_in = ecpr_pkg::ST_INS_LINK;
            end
         end
         ecpr_pkg::ST_INS_LINK: begin
            flag_addr  = idx_ff;
            op.link_we = 1'b1;
            link_waddr = idx_ff;
            link_wdata = (count_ff == '0) ? idx_ff : link_rdata;
            op.page_we = 1'b1;
            state_in   = ecpr_pkg::ST_INS_HAND;
         end
         ecpr_pkg::ST_INS_HAND: begin
            flag_addr  = idx_ff;
            op.flag_op = ecpr_pkg::FLAG_FILL;
            if (count_ff != '0) begin
               op.link_we = 1'b1;
               link_waddr = hand_ff;
               link_wdata = idx_ff;
            end
            hand_in         = idx_ff;
            count_in        = count_ff + CW'(1);
            res_in.slot_out = ecpr_pkg::SLOT_FIELD_W'(idx_ff);
            state_in        = ecpr_pkg::ST_FINISH;
         end
         ecpr_pkg::ST_VIC_FIRST: begin
            cur_in     = link_rdata;
            link_raddr = link_rdata;
            page_raddr = link_rdata;
            state_in   = ecpr_pkg::ST_VIC_EVAL;
         end
         ecpr_pkg::ST_VIC_EVAL: begin
            flag_addr = cur_ff;
            if (victim) begin
               op.link_we         = 1'b1;
               link_waddr         = prev_ff;
               link_wdata         = link_rdata;
               op.flag_op         = ecpr_pkg::FLAG_FREE;
               hand_in            = prev_ff;
               count_in           = count_ff - CW'(1);
               res_in.victim_page = ecpr_pkg::PAGE_NUMBER_W'(page_rdata);
               res_in.slot_out    = ecpr_pkg::SLOT_FIELD_W'(cur_ff);
               state_in           = ecpr_pkg::ST_FINISH;
            end else begin
               unique case (pass_ff)
                  2'd0:    op.flag_op = ecpr_pkg::FLAG_CLR_ACC;
                  2'd1:    op.flag_op = ecpr_pkg::FLAG_CLR_DIRTY;
                  default: op.flag_op = ecpr_pkg::FLAG_NONE;
               endcase
               prev_in    = cur_ff;
               cur_in     = link_rdata;
               link_raddr = link_rdata;
               page_raddr = link_rdata;
               if (last_k) begin
                  k_in    = '0;
                  pass_in = pass_ff + 2'd1;
                  if (pass_ff == 2'(ecpr_pkg::SCAN_PASSES - 1)) begin
                     res_in.status = ecpr_pkg::STATUS_EMPTY;
                     state_in      = ecpr_pkg::ST_FINISH;
                  end
               end else begin
                  k_in = k_ff + CW'(1);
               end
            end
         end
         ecpr_pkg::ST_FINISH: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ecpr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ecpr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecpr_pkg::ST_IDLE;
         hand_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         hand_ff  <= hand_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      pass_ff <= pass_in;
      k_ff    <= k_in;
      page_ff <= page_in;
      res_ff  <= res_in;
   end

   assign result = res_ff;

   `ECPR_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(FRAMES), "resident count above frames")
   `ECPR_ASSERT_IMPLIES(a_fill_free_slot, clock, reset, state_ff == ecpr_pkg::ST_INS_LINK, !flags.used, "insert chose a used slot")
   `ECPR_ASSERT_NEXT(a_victim_frees, clock, reset, (state_ff == ecpr_pkg::ST_VIC_EVAL) && victim, count_ff == $past(count_ff) - CW'(1), "eviction did not drop resident count")

endmodule

`default_nettype wire

[hw/rtl/enhanced_clock_page_replacement_top.sv]
// Enhanced second-chance clock page replacement over FRAMES slots. A request
// carries one of three commands: insert a page (answered with the slot it was
// given, or status 2 when every slot is taken), mark an access to a slot
// (sets the accessed bit, and the dirty bit on a write; unused or
// out-of-range slots are ignored), or select a victim (answered with the
// evicted page and its slot, or status 1 on an empty ring). Every request
// gets exactly one response. Requests are handled one at a time: an insert
// steps over each used slot below the lowest free one, and a victim search
// examines at most 2 x resident pages + 1 slots. The scan loop walks the
// ring through the registered read port of the link memory, one slot a
// cycle. A finished response waits in the output register, and the next
// request is taken while it waits. No clearing pass follows reset.
// depends on ecpr_pkg, ecpr_ifs, ecpr_frame_store and ecpr_sequencer
`default_nettype none

module enhanced_clock_page_replacement_top #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 20
) (
   input wire          clock,
   input wire          reset,
   ecpr_req_if.sink    req_bus,
   ecpr_rsp_if.source  rsp_bus
);

   // slot index width, at least one bit for a single frame
   localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   ecpr_pkg::store_op_type store_op;
   ecpr_pkg::flags_type    flags;
   ecpr_pkg::result_type   seq_result;
   logic                   seq_done;
   logic                   seq_ready;
   logic                   out_free;

   logic [SLOT_W-1:0]    link_waddr;
   logic [SLOT_W-1:0]    link_wdata;
   logic [SLOT_W-1:0]    link_raddr;
   logic [SLOT_W-1:0]    link_rdata;
   logic [SLOT_W-1:0]    page_waddr;
   logic [PAGE_BITS-1:0] page_wdata;
   logic [SLOT_W-1:0]    page_raddr;
   logic [PAGE_BITS-1:0] page_rdata;
   logic [SLOT_W-1:0]    flag_addr;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   ecpr_pkg::result_type rsp_data_ff, rsp_data_in;

   // the response slot frees up in the cycle it is taken
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   ecpr_sequencer #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .SLOT_W    (SLOT_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (seq_ready),
      .req        (req_bus.payload),
      .out_free   (out_free),
      .done       (seq_done),
      .result     (seq_result),
      .op         (store_op),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .link_raddr (link_raddr),
      .link_rdata (link_rdata),
      .page_waddr (page_waddr),
      .page_wdata (page_wdata),
      .page_raddr (page_raddr),
      .page_rdata (page_rdata),
      .flag_addr  (flag_addr),
      .flags      (flags)
   );

   // page memory, ring links and accessed / dirty / used bits
   ecpr_frame_store #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .SLOT_W    (SLOT_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .op         (store_op),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .link_raddr (link_raddr),
      .link_rdata (link_rdata),
      .page_waddr (page_waddr),
      .page_wdata (page_wdata),
      .page_raddr (page_raddr),
      .page_rdata (page_rdata),
      .flag_addr  (flag_addr),
      .flags      (flags)
   );

   // load on completion, drop once the consumer takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_result;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_bus.ready   = seq_ready;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

endmodule

`default_nettype wire

[test/ecpr_outcome_checker.sv]
// response checker for the clock page replacement block: keeps its own copy of
// the frame ring, works out each response and compares it with the dut
// depends on ecpr_pkg for the request and response structs and codes
`default_nettype none

module ecpr_outcome_checker
   import ecpr_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input wire          clock,
   input wire          reset,
   input wire          req_valid,
   input wire          req_ready,
   input request_type  req_payload,
   input wire          rsp_valid,
   input wire          rsp_ready,
   input result_type   rsp_payload,
   output int          mismatch_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLEAR_ACCESSED_PASS = 0;
   localparam int CLEAR_DIRTY_PASS    = 1;

   logic [PAGE_NUMBER_W-1:0] frame_page [SLOTS];
   logic [SLOT_FIELD_W-1:0]  next_in_ring [SLOTS];
   logic                     accessed_flag [SLOTS];
   logic                     dirty_flag [SLOTS];
   logic                     frame_used [SLOTS];
   logic [SLOT_FIELD_W-1:0]  hand;
   int                       resident;

   result_type awaited_responses [$];
   result_type due;
   int         mismatches;

   // expected response of one request, updating the shadow ring
   function automatic result_type clock_ring_outcome(input request_type item);
      result_type outcome;
      int         free_slot;
      int         prev_slot;
      int         cur_slot;
      bit         found;
      outcome   = '0;
      free_slot = SLOTS;
      found     = 1'b0;
      case (item.cmd)
         CMD_INSERT: begin
            for (int s = SLOTS - 1; s >= 0; s--) begin
               if (!frame_used[s]) free_slot = s;
            end
            if (free_slot == SLOTS) begin
               outcome.status = STATUS_FULL;
            end else begin
               frame_page[free_slot]    = item.page_number;
               accessed_flag[free_slot] = 1'b0;
               dirty_flag[free_slot]    = 1'b0;
               frame_used[free_slot]    = 1'b1;
               if (resident == 0) begin
                  next_in_ring[free_slot] = SLOT_FIELD_W'(free_slot);
               end else begin
                  next_in_ring[free_slot] = next_in_ring[hand];
                  next_in_ring[hand]      = SLOT_FIELD_W'(free_slot);
               end
               hand     = SLOT_FIELD_W'(free_slot);
               resident = resident + 1;
               outcome.slot_out = SLOT_FIELD_W'(free_slot);
            end
         end
         CMD_ACCESS: begin
            if (item.slot_index < SLOTS && frame_used[item.slot_index]) begin
               accessed_flag[item.slot_index] = 1'b1;
               if (item.write_access) dirty_flag[item.slot_index] = 1'b1;
            end
         end
         CMD_VICTIM: begin
            if (resident == 0) begin
               outcome.status = STATUS_EMPTY;
            end else begin
               for (int pass = 0; pass < SCAN_PASSES && !found; pass++) begin
                  prev_slot = int'(hand);
                  cur_slot  = int'(next_in_ring[hand]);
                  for (int k = 0; k < resident && !found; k++) begin
                     if (!accessed_flag[cur_slot] && !dirty_flag[cur_slot]) begin
                        found = 1'b1;
                        next_in_ring[prev_slot] = next_in_ring[cur_slot];
                        hand                    = SLOT_FIELD_W'(prev_slot);
                        frame_used[cur_slot]    = 1'b0;
                        resident                = resident - 1;
                        outcome.victim_page     = frame_page[cur_slot];
                        outcome.slot_out        = SLOT_FIELD_W'(cur_slot);
                     end else begin
                        if (pass == CLEAR_ACCESSED_PASS) accessed_flag[cur_slot] = 1'b0;
                        else if (pass == CLEAR_DIRTY_PASS) dirty_flag[cur_slot] = 1'b0;
                        prev_slot = cur_slot;
                        cur_slot  = int'(next_in_ring[cur_slot]);
                     end
                  end
               end
               // a consistent ring always yields a page by the last pass
               if (!found) outcome.status = STATUS_EMPTY;
            end
         end
         default: begin
         end
      endcase
      return outcome;
   endfunction

   function automatic void check_field(input string field, input int expected,
                                       input int actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, expected, actual);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            accessed_flag[s] = 1'b0;
            dirty_flag[s]    = 1'b0;
            frame_used[s]    = 1'b0;
         end
         hand       = '0;
         resident   = 0;
         mismatches = 0;
         awaited_responses.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_responses.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, got %h",
                        $time, rsp_payload);
               mismatches++;
            end else begin
               due = awaited_responses.pop_front();
               check_field("victim_page", due.victim_page, rsp_payload.victim_page);
               check_field("slot_out", due.slot_out, rsp_payload.slot_out);
               check_field("status", due.status, rsp_payload.status);
            end
         end
         if (req_valid && req_ready) awaited_responses.push_back(clock_ring_outcome(req_payload));
      end
      mismatch_count <= mismatches;
      pending_count  <= awaited_responses.size();
   end

endmodule

`default_nettype wire

[test/testbench.sv]
// top of the clock page replacement testbench: clock, reset, request and
// response stimulus with idling phases, watchdog and final verdict
// depends on ecpr_pkg, ecpr_ifs, ecpr_outcome_checker and the dut top
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ecpr_pkg::*;

   localparam int SLOTS          = 8;
   localparam int RESET_CYCLES   = 11;
   localparam int PHASE_ITEMS    = 282;
   localparam int PRESSURE_HOLD  = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 60;

   // the one command value the block does not decode
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   logic clock;
   logic reset;

   ecpr_req_if req_ch ();
   ecpr_rsp_if rsp_ch ();

   int mismatch_count;
   int pending_results;

   // idling shares per phase, in percent of cycles
   int sender_idle_pct;
   int receiver_stall_pct;

   // long receiver hold-off: asked for by the stimulus, carried out by the receiver
   int pressure_asks;
   int pressure_served;
   int hold_left;

   // pages resident as seen from the request stream alone
   int resident_estimate;
   int idle_cycles;

   enhanced_clock_page_replacement_top #(
      .FRAMES    (SLOTS),
      .PAGE_BITS (PAGE_NUMBER_W)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   ecpr_outcome_checker #(
      .SLOTS (SLOTS)
   ) outcome_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_payload    (req_ch.payload),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_payload    (rsp_ch.payload),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_results)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // response side: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (pressure_served != pressure_asks) begin
         pressure_served = pressure_served + 1;
         hold_left       = PRESSURE_HOLD - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // watchdog: too many cycles without any handshake on either side
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or response moved for %0d cycles", $time, idle_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic request_type make_request(input logic [CMD_W-1:0] cmd,
                                                input logic [PAGE_NUMBER_W-1:0] page,
                                                input logic [SLOT_FIELD_W-1:0] slot,
                                                input logic write_flag);
      request_type item;
      item.cmd          = cmd;
      item.page_number  = page;
      item.slot_index   = slot;
      item.write_access = write_flag;
      return item;
   endfunction

   // page numbers lean toward the field extremes now and then
   function automatic logic [PAGE_NUMBER_W-1:0] random_page();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return PAGE_NUMBER_W'($urandom());
      endcase
   endfunction

   // one request weighted by how full the ring is, so it keeps cycling
   // between empty and full; all fields carry random bits whatever the command
   function automatic request_type random_request();
      request_type item;
      int          pick;
      int          insert_share;
      int          victim_share;
      item = make_request(CMD_ACCESS, random_page(),
                          SLOT_FIELD_W'($urandom_range(0, SLOTS - 1)),
                          1'($urandom_range(0, 1)));
      insert_share = (resident_estimate < 4) ? 40 : 22;
      victim_share = (resident_estimate > 4) ? 28 : 14;
      pick = $urandom_range(0, 99);
      if (pick < 4) item.cmd = CMD_RESERVED;
      else if (pick < 4 + insert_share) item.cmd = CMD_INSERT;
      else if (pick < 4 + insert_share + victim_share) item.cmd = CMD_VICTIM;
      return item;
   endfunction

   // offer one request and hold it until the block takes it;
   // valid stays high straight into the next request unless the sender idles
   task automatic offer_request(input request_type item);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (item.cmd == CMD_INSERT && resident_estimate < SLOTS)
         resident_estimate = resident_estimate + 1;
      else if (item.cmd == CMD_VICTIM && resident_estimate > 0)
         resident_estimate = resident_estimate - 1;
   endtask

   // fixed opening: empty ring, unused command, fill to full, full insert,
   // all slots accessed and dirty so the victim needs the third pass,
   // an access to a freed slot, slot reuse after eviction
   task automatic run_directed();
      offer_request(make_request(CMD_VICTIM, '0, '0, 1'b0));
      offer_request(make_request(CMD_RESERVED, '1, '1, 1'b1));
      offer_request(make_request(CMD_ACCESS, 20'h00000, 3'd5, 1'b1));
      offer_request(make_request(CMD_INSERT, 20'h00000, 3'd0, 1'b0));
      offer_request(make_request(CMD_INSERT, 20'hFFFFF, 3'd7, 1'b1));
      offer_request(make_request(CMD_INSERT, 20'hAAAAA, 3'd0, 1'b0));
      offer_request(make_request(CMD_INSERT, 20'h55555, 3'd0, 1'b0));
      offer_request(make_request(CMD_INSERT, 20'h00001, 3'd0, 1'b0));
      offer_request(make_request(CMD_INSERT, 20'h80000, 3'd0, 1'b0));
      offer_request(make_request(CMD_INSERT, 20'h7FFFF, 3'd0, 1'b0));
      offer_request(make_request(CMD_INSERT, 20'h12345, 3'd0, 1'b0));
      offer_request(make_request(CMD_INSERT, 20'hFEDCB, 3'd0, 1'b0));
      for (int s = 0; s < SLOTS; s++)
         offer_request(make_request(CMD_ACCESS, '0, SLOT_FIELD_W'(s), 1'b1));
      offer_request(make_request(CMD_VICTIM, '0, '0, 1'b0));
      offer_request(make_request(CMD_ACCESS, '0, 3'd0, 1'b1));
      offer_request(make_request(CMD_ACCESS, '0, 3'd3, 1'b0));
      offer_request(make_request(CMD_VICTIM, '0, '0, 1'b0));
      offer_request(make_request(CMD_INSERT, 20'h3C3C3, 3'd0, 1'b0));
   endtask

   // random part: mostly single requests, sometimes a burst that marks
   // every slot and then asks for a victim, which pushes the scan deep
   task automatic run_random(input int count);
      int issued;
      issued = 0;
      while (issued < count) begin
         if ($urandom_range(0, 99) < 12) begin
            for (int s = 0; s < SLOTS; s++)
               offer_request(make_request(CMD_ACCESS, PAGE_NUMBER_W'($urandom()),
                                          SLOT_FIELD_W'(s),
                                          ($urandom_range(0, 3) != 0)));
            offer_request(make_request(CMD_VICTIM, PAGE_NUMBER_W'($urandom()),
                                       SLOT_FIELD_W'($urandom()),
                                       1'($urandom_range(0, 1))));
            issued = issued + SLOTS + 1;
         end else begin
            offer_request(random_request());
            issued = issued + 1;
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.payload     = '0;
      rsp_ch.ready       = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      pressure_asks      = 0;
      pressure_served    = 0;
      hold_left          = 0;
      resident_estimate  = 0;
      idle_cycles        = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // no idling, with a long response hold-off so the block backs up
      run_directed();
      pressure_asks <= pressure_asks + 1;
      run_random(PHASE_ITEMS);

      // sender idle most cycles
      sender_idle_pct = 71;
      run_random(PHASE_ITEMS);

      // receiver stalling most cycles
      sender_idle_pct = 0;
      receiver_stall_pct <= 71;
      run_random(PHASE_ITEMS);

      // light idling on both sides, and a second hold-off
      sender_idle_pct = 16;
      receiver_stall_pct <= 16;
      pressure_asks <= pressure_asks + 1;
      run_random(PHASE_ITEMS);

      req_ch.valid <= 1'b0;
      // the pending count is registered in the checker, so it lags the last request
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_results == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
